/* hdl/dct_pkg.sv */
// ----------------------------------------------------------------------------
// dct_pkg: shared types and codes for the debounced capture trigger
// Command codes, event codes, pin level codes, and the state and result
// records passed between the core and its per-tick update logic.
// ----------------------------------------------------------------------------
package dct_pkg;

  localparam int unsigned LockoutWidth = 20;
  localparam int unsigned FrameWidth   = 32;
  localparam int unsigned ElapsedWidth = 48;

  localparam logic [LockoutWidth-1:0] LOCKOUT_RESET = LockoutWidth'(10000);
  localparam logic [LockoutWidth-1:0] EDGE_MAX      = '1;
  localparam logic [ElapsedWidth-1:0] ELAPSED_MAX   = '1;

  // command codes
  localparam logic [2:0] FUNC_NONE   = 3'd0;
  localparam logic [2:0] FUNC_START  = 3'd1;
  localparam logic [2:0] FUNC_STOP   = 3'd2;
  localparam logic [2:0] FUNC_QRESET = 3'd3;
  localparam logic [2:0] FUNC_ALLOC  = 3'd4;

  // change event codes
  localparam logic [1:0] EVT_NONE     = 2'd0;
  localparam logic [1:0] EVT_ACTIVE   = 2'd1;
  localparam logic [1:0] EVT_INACTIVE = 2'd2;

  // accepted pin level codes
  localparam logic [1:0] LVL_LOW     = 2'd0;
  localparam logic [1:0] LVL_HIGH    = 2'd1;
  localparam logic [1:0] LVL_UNKNOWN = 2'd2;

  typedef struct packed {
    logic [1:0]              known_level;
    logic [LockoutWidth-1:0] edge_ticks;
    logic                    active;
    logic                    session;
    logic [FrameWidth-1:0]   frame_cnt;
    logic                    last_rep;
  } trig_state_t;

  typedef struct packed {
    logic                    active;
    logic                    session_valid;
    logic [ElapsedWidth-1:0] elapsed_ticks;
    logic [FrameWidth-1:0]   frame_id;
    logic [1:0]              change_event;
  } trig_result_t;

endpackage

/* hdl/dct_step.sv */
// ----------------------------------------------------------------------------
// dct_step: one-tick update of the trigger state
// Advances the timers, applies the debounced pin edge, then the command,
// and forms the result word.
// ----------------------------------------------------------------------------
module dct_step
  import dct_pkg::*;
#(
  parameter int unsigned TIME_WIDTH = 48
) (
  input  trig_state_t               state_i,
  input  logic [TIME_WIDTH-1:0]     sess_ticks_i,
  input  logic [LockoutWidth-1:0]   lockout_i,
  input  logic                      pin_level_i,
  input  logic [2:0]                func_i,
  output trig_state_t               state_o,
  output logic [TIME_WIDTH-1:0]     sess_ticks_o,
  output trig_result_t              result_o
);

  localparam int unsigned EW = (TIME_WIDTH > ElapsedWidth) ? TIME_WIDTH : ElapsedWidth;
  localparam logic [TIME_WIDTH-1:0] SESSION_MAX = '1;

  trig_state_t           st;
  logic [TIME_WIDTH-1:0] sess;
  logic [1:0]            evt;
  logic [FrameWidth-1:0] frame_out;
  logic [EW-1:0]         elapsed_w;
  logic                  edge_ok;

  always_comb begin
    st        = state_i;
    sess      = sess_ticks_i;
    evt       = EVT_NONE;
    frame_out = '0;

    // advance timers, saturating
    if (st.edge_ticks != EDGE_MAX) begin
      st.edge_ticks = st.edge_ticks + 1'b1;
    end
    if (st.session && (sess != SESSION_MAX)) begin
      sess = sess + 1'b1;
    end

    // debounced pin edge
    edge_ok = (st.known_level != {1'b0, pin_level_i}) &&
              ((st.known_level == LVL_UNKNOWN) || (st.edge_ticks >= lockout_i));
    if (edge_ok) begin
      st.edge_ticks  = '0;
      st.known_level = pin_level_i ? LVL_HIGH : LVL_LOW;
      if (pin_level_i) begin
        st.session   = 1'b1;
        sess         = '0;
        st.frame_cnt = '0;
        st.active    = 1'b1;
      end else begin
        st.active = 1'b0;
      end
      if (st.active != st.last_rep) begin
        st.last_rep = st.active;
        evt         = st.active ? EVT_ACTIVE : EVT_INACTIVE;
      end
    end

    // command after the pin
    case (func_i)
      FUNC_START: begin
        st.session   = 1'b1;
        sess         = '0;
        st.frame_cnt = '0;
        st.active    = 1'b1;
        evt          = EVT_ACTIVE;
      end
      FUNC_STOP: begin
        st.active  = 1'b0;
        st.session = 1'b0;
        sess       = '0;
        evt        = EVT_INACTIVE;
      end
      FUNC_QRESET: begin
        st.active    = 1'b0;
        st.session   = 1'b0;
        sess         = '0;
        st.frame_cnt = '0;
      end
      FUNC_ALLOC: begin
        st.frame_cnt = st.frame_cnt + 1'b1;
        frame_out    = st.frame_cnt;
      end
      default: begin
      end
    endcase

    // clamp elapsed to the output width
    elapsed_w = st.session ? EW'(sess) : '0;
    if (elapsed_w > EW'(ELAPSED_MAX)) begin
      elapsed_w = EW'(ELAPSED_MAX);
    end
  end

  assign state_o      = st;
  assign sess_ticks_o = sess;

  assign result_o.active        = st.active;
  assign result_o.session_valid = st.session;
  assign result_o.elapsed_ticks = elapsed_w[ElapsedWidth-1:0];
  assign result_o.frame_id      = frame_out;
  assign result_o.change_event  = evt;

endmodule

/* hdl/debounced_capture_trigger_core.sv */
// ----------------------------------------------------------------------------
// debounced_capture_trigger_core: debounced trigger with lockout and timestamp
// Tracks a capture session from a debounced trigger pin and manual commands,
// one word per microsecond tick, and reports activity, elapsed ticks and
// allocated frame numbers.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_o): one word per microsecond tick,
//   carrying the sampled pin level and a command code. Every accepted word
//   gives exactly one result word on the output channel
//   (out_valid_o / out_stall_i), in order.
//   Path: an accepted word is held in the input register, then passes
//   through the update logic into the result register.
//   Throughput: one word per cycle unless the receiver stalls; the state
//   update is a single pass of short logic (a 48-bit saturating add, a
//   20-bit compare against the lockout and a 32-bit frame increment)
//   between the two registers.
//   Receiver stall: the result register holds; the input register still
//   takes a word while empty, and in_stall_o rises only when both are full.
//   Reset: state returns to unknown pin level, no session, inactive, frame
//   counter zero, lockout 10000 ticks; both registers empty.
//   Configuration: cfg_we_i writes the 20-bit lockout; write it only while
//   no word is in flight.
// ----------------------------------------------------------------------------
module debounced_capture_trigger_core
  import dct_pkg::*;
#(
  parameter int unsigned TIME_WIDTH = 48
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_we_i,
  input  logic [LockoutWidth-1:0] cfg_wdata_i,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic                    pin_level_i,
  input  logic [2:0]              func_i,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic                    active_o,
  output logic                    session_valid_o,
  output logic [ElapsedWidth-1:0] elapsed_ticks_o,
  output logic [FrameWidth-1:0]   frame_id_o,
  output logic [1:0]              change_event_o
);

  logic [LockoutWidth-1:0] lockout_q;

  // input register
  logic       in_valid_q;
  logic       pin_q;
  logic [2:0] func_q;

  // trigger state
  trig_state_t           state_q, state_d;
  logic [TIME_WIDTH-1:0] sess_q, sess_d;

  // result register
  logic         out_valid_q;
  trig_result_t result_q, result_d;

  logic out_adv;
  logic in_take;
  logic step;

  // advance the result register when it is empty or being taken
  assign out_adv    = !out_valid_q || !out_stall_i;
  assign step       = in_valid_q && out_adv;
  assign in_stall_o = in_valid_q && !out_adv;
  assign in_take    = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lockout_q <= LOCKOUT_RESET;
    end else if (cfg_we_i) begin
      lockout_q <= cfg_wdata_i;
    end
  end

  // input register: take a word whenever it is free or draining
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      pin_q  <= pin_level_i;
      func_q <= func_i;
    end
  end

  dct_step #(
    .TIME_WIDTH(TIME_WIDTH)
  ) u_step (
    .state_i     (state_q),
    .sess_ticks_i(sess_q),
    .lockout_i   (lockout_q),
    .pin_level_i (pin_q),
    .func_i      (func_q),
    .state_o     (state_d),
    .sess_ticks_o(sess_d),
    .result_o    (result_d)
  );

  // commit the state only when the word moves into the result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q.known_level <= LVL_UNKNOWN;
      state_q.edge_ticks  <= '0;
      state_q.active      <= 1'b0;
      state_q.session     <= 1'b0;
      state_q.frame_cnt   <= '0;
      state_q.last_rep    <= 1'b0;
      sess_q              <= '0;
    end else if (step) begin
      state_q <= state_d;
      sess_q  <= sess_d;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_adv) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      result_q <= result_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign active_o        = result_q.active;
  assign session_valid_o = result_q.session_valid;
  assign elapsed_ticks_o = result_q.elapsed_ticks;
  assign frame_id_o      = result_q.frame_id;
  assign change_event_o  = result_q.change_event;

  // an active trigger always has a session behind it
  a_active_has_session : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && active_o |-> session_valid_o)
    else $error("active without a session");

  // no session means no elapsed time
  a_no_session_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !session_valid_o |-> elapsed_ticks_o == '0)
    else $error("elapsed ticks without a session");

  // an inactive report always leaves the trigger inactive; an active report
  // may be followed by a quiet reset in the same tick
  a_event_matches : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (change_event_o == EVT_INACTIVE) |-> !active_o)
    else $error("change event disagrees with active flag");

  // an empty input register never stalls the sender
  a_no_stall_empty : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_valid_q |-> !in_stall_o)
    else $error("stall with empty input register");

endmodule
